FILE: hdl/multi_reference_sad_macros.svh
// ----------------------------------------------------------------------------
// multi_reference_sad_macros.svh
// Assertion shorthands shared by the SAD block.
// ----------------------------------------------------------------------------
`ifndef MULTI_REFERENCE_SAD_MACROS_SVH
`define MULTI_REFERENCE_SAD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRSAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRSAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mrsad_pkg.sv
// ----------------------------------------------------------------------------
// mrsad_pkg
// Shared types, constants and helpers of the multi-reference SAD block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrsad_pkg;

    localparam int SUM_BITS  = 20;
    localparam int SIZE_BITS = 7;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [SUM_BITS-1:0]  SUM_MAX    = {SUM_BITS{1'b1}};
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(64);

    typedef logic [SIZE_BITS-1:0] size_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BLOCK_WIDTH  = 1'b0,
        REG_BLOCK_HEIGHT = 1'b1
    } cfg_reg_t;

    // per-lane control, one word per cycle
    typedef struct packed {
        logic advance;   // a pixel is consumed this cycle
        logic clear;     // it is the last pixel of the block
    } lane_ctrl_t;

    // index of the last column/row; a size of zero acts as one
    function automatic size_t last_index(input size_t size);
        last_index = (size == '0) ? '0 : size - size_t'(1);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mrsad_lane.sv
// ----------------------------------------------------------------------------
// mrsad_lane
// One reference way: absolute difference and saturating running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsad_lane
    import mrsad_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lane_ctrl_t             ctrl,
    input  wire logic [SAMPLE_BITS-1:0] src_sample,
    input  wire logic [SAMPLE_BITS-1:0] ref_sample,
    output logic      [SUM_BITS-1:0]    sum_total
);

    logic [SAMPLE_BITS-1:0] diff;
    logic [SUM_BITS:0]      sum_wide;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;

    assign diff     = (src_sample >= ref_sample) ? src_sample - ref_sample
                                                 : ref_sample - src_sample;
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS+1)'(diff);
    // saturate on carry out
    assign sum_total = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.advance) begin
            sum_next = ctrl.clear ? '0 : sum_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/multi_reference_sad.sv
// ----------------------------------------------------------------------------
// multi_reference_sad
// Block-matching cost: running SAD of one source block against several
// candidate reference blocks, one result word per block.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  -------------------------------------------
//  s_       in   s_tvalid/s_tready  source pixel + one sample per reference way
//  m_       out  m_tvalid/m_tready  one 20-bit cost per way, once per block
//  cfg_     in   cfg_wr_en          block_width (0), block_height (1)
//
//  One word per clock sustained while the m_ side keeps up. Path: input
//  register, then the lane add/saturate and the result register, which takes
//  the block's costs once its last pixel fires with the m_ side free.
//  Reset (aresetn, synchronous) clears sums, counters, valids; sizes go to 64.
//  The input stalls only when a block ends while the previous result word is
//  still held by a stalled m_ side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_reference_sad_macros.svh"

module multi_reference_sad
    import mrsad_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    parameter int REF_WAYS    = 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    // slave stream; tdata from bit 0: source_pixel, reference_a, _b, _c, ...
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [((((REF_WAYS+1)*SAMPLE_BITS)+7)/8)*8-1:0] s_tdata,

    // master stream; tdata from bit 0: cost_a, cost_b, cost_c, ... zero pad
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [(((REF_WAYS*SUM_BITS)+7)/8)*8-1:0] m_tdata,

    // configuration write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [SIZE_BITS-1:0]      cfg_wdata
);

    localparam int OUT_BITS  = REF_WAYS * SUM_BITS;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    // ---- configuration ----
    size_t width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_BLOCK_WIDTH) begin
                width_reg <= cfg_wdata;
            end else if (cfg_index == REG_BLOCK_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    // ---- input register ----
    logic                                 in_valid_reg;
    logic [SAMPLE_BITS-1:0]               src_reg;
    logic [REF_WAYS-1:0][SAMPLE_BITS-1:0] ref_reg;
    logic                                 s_take;

    assign s_take = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            src_reg <= s_tdata[SAMPLE_BITS-1:0];
            for (int w = 0; w < REF_WAYS; w++) begin
                ref_reg[w] <= s_tdata[(w+1)*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // ---- position counters ----
    size_t col_count_reg, col_count_next;
    size_t row_count_reg, row_count_next;
    logic  row_end, block_end, fire, out_free;

    assign row_end   = col_count_reg >= last_index(width_reg);
    assign block_end = row_end && (row_count_reg >= last_index(height_reg));

    // a pixel is consumed unless it ends a block and the result slot is busy
    assign out_free = !m_tvalid || m_tready;
    assign fire     = in_valid_reg && (!block_end || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (fire) begin
            if (!row_end) begin
                col_count_next = col_count_reg + size_t'(1);
            end else begin
                col_count_next = '0;
                row_count_next = block_end ? '0 : row_count_reg + size_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ---- reference lanes ----
    lane_ctrl_t                        lane_ctrl;
    logic [REF_WAYS-1:0][SUM_BITS-1:0] lane_total;

    assign lane_ctrl.advance = fire;
    assign lane_ctrl.clear   = block_end;

    for (genvar g = 0; g < REF_WAYS; g++) begin : g_lane
        mrsad_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .src_sample(src_reg),
            .ref_sample(ref_reg[g]),
            .sum_total (lane_total[g])
        );
    end

    // ---- result register ----
    logic                              out_valid_reg;
    logic [REF_WAYS-1:0][SUM_BITS-1:0] cost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && block_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && block_end) begin
            cost_reg <= lane_total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA'(cost_reg);

    // ---- checks ----
    `MRSAD_ASSERT_NEXT(a_block_end_clears, aclk, aresetn, fire && block_end, col_count_reg == '0 && row_count_reg == '0, "counters not cleared after block end")
    `MRSAD_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready, in_valid_reg && out_valid_reg && !m_tready, "input stalled without a held result")
    `MRSAD_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_tvalid), $past(fire && block_end), "result raised without a block end")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_reference_sad. Pixel words go in on the s_
// stream and are tracked by a cost tracker that keeps its own running sums,
// column and row counts. Every cost word on the m_ stream is compared lane
// by lane with the oldest predicted one. The run covers the reset size, a
// full-scale block of the widest rows, zero and oversize settings, size
// changes between blocks and part-way through a block, a long output stall,
// and random size phases with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrsad_pkg::*;

    localparam int SAMPLE_W     = 8;
    localparam int WAYS         = 4;
    localparam int LATENCY      = 1;     // settle margin added after the last cost word
    localparam int RANDOM_WORDS = 1050;  // pixel words in the random phases

    // s_tdata from bit 0: source_pixel, reference_a, reference_b, _c, _d
    typedef struct packed {
        logic [WAYS-1:0][SAMPLE_W-1:0] refs;
        logic [SAMPLE_W-1:0]           source;
    } pixel_word_t;

    // m_tdata from bit 0: cost_a, cost_b, cost_c, cost_d
    typedef logic [WAYS-1:0][SUM_BITS-1:0] cost_word_t;

    // ------------------------------------------------------------------------
    // Cost tracker: running SAD per way, raster counters, expected cost words
    // ------------------------------------------------------------------------
    class block_cost_tracker;
        size_t               width, height;
        size_t               column, row;
        logic [SUM_BITS-1:0] sums [WAYS];
        cost_word_t          expected_costs [$];
        int                  errors;
        int                  words_checked;

        function new();
            width         = SIZE_RESET;
            height        = SIZE_RESET;
            column        = '0;
            row           = '0;
            errors        = 0;
            words_checked = 0;
            foreach (sums[i]) sums[i] = '0;
        endfunction

        function void set_size(cfg_reg_t idx, size_t value);
            if (idx == REG_BLOCK_WIDTH) begin
                width = value;
            end else begin
                height = value;
            end
        endfunction

        function int pending();
            return expected_costs.size();
        endfunction

        // Accumulate one accepted pixel word; predict a cost word at block end.
        function void note_pixel(pixel_word_t px);
            logic [SAMPLE_W-1:0] diff;
            logic [SUM_BITS:0]   total;
            size_t               col_last, row_last;
            cost_word_t          word;
            for (int i = 0; i < WAYS; i++) begin
                diff  = (px.source >= px.refs[i]) ? px.source - px.refs[i]
                                                  : px.refs[i] - px.source;
                total = {1'b0, sums[i]} + (SUM_BITS+1)'(diff);
                sums[i] = (total > SUM_MAX) ? SUM_MAX : total[SUM_BITS-1:0];
            end
            // size zero behaves as one
            col_last = (width  == '0) ? '0 : width  - size_t'(1);
            row_last = (height == '0) ? '0 : height - size_t'(1);
            if (column < col_last) begin
                column = column + size_t'(1);
                return;
            end
            column = '0;
            if (row < row_last) begin
                row = row + size_t'(1);
                return;
            end
            row = '0;
            for (int i = 0; i < WAYS; i++) begin
                word[i] = sums[i];
                sums[i] = '0;
            end
            expected_costs.push_back(word);
        endfunction

        function void check_costs(cost_word_t got);
            cost_word_t want;
            string      lanes;
            lanes = "abcd";
            if (expected_costs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: cost word %h with none expected", $realtime, got);
                return;
            end
            want = expected_costs.pop_front();
            words_checked++;
            for (int i = 0; i < WAYS; i++) begin
                if (got[i] !== want[i]) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: cost_%c mismatch, expected %0d, got %0d",
                                 $realtime, lanes[i], want[i], got[i]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    pixel_word_t s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    cost_word_t  m_tdata;
    logic        cfg_wr_en = 1'b0;
    cfg_reg_t    cfg_index = REG_BLOCK_WIDTH;
    size_t       cfg_wdata = '0;

    block_cost_tracker costs_model = new();

    // idling controls, set per phase by the stimulus
    bit tx_idle       = 1'b0;
    bit rx_idle       = 1'b0;
    int rx_hold_cycles = 0;    // one-off long hold-off, counted down below
    int rx_stall      = 0;

    // run statistics
    int words_sent    = 0;
    int random_words  = 0;
    int size_writes   = 0;
    int input_stalls  = 0;

    multi_reference_sad i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic pixel_word_t make_px(logic [7:0] src, logic [7:0] a,
                                            logic [7:0] b, logic [7:0] c,
                                            logic [7:0] d);
        pixel_word_t px;
        px.source  = src;
        px.refs[0] = a;
        px.refs[1] = b;
        px.refs[2] = c;
        px.refs[3] = d;
        return px;
    endfunction

    // Random content: plain random, rail values, near misses, exact matches.
    function automatic pixel_word_t random_pixel();
        pixel_word_t px;
        int          mode, v;
        mode      = $urandom_range(0, 9);
        px.source = SAMPLE_W'($urandom_range(0, 255));
        if (mode == 6)
            px.source = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        for (int i = 0; i < WAYS; i++) begin
            case (mode)
                6: begin
                    px.refs[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                7: begin
                    v = int'(px.source) + int'($urandom_range(0, 6)) - 3;
                    px.refs[i] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : v[7:0];
                end
                8: begin
                    px.refs[i] = px.source;
                end
                default: begin
                    px.refs[i] = SAMPLE_W'($urandom_range(0, 255));
                end
            endcase
        end
        return px;
    endfunction

    // Mostly small sizes; zero, one, the reset size and oversize now and then.
    function automatic size_t pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)  return '0;
        if (r == 1)  return size_t'(1);
        if (r < 12)  return size_t'($urandom_range(2, 8));
        if (r < 17)  return size_t'($urandom_range(4, 16));
        if (r == 17) return size_t'(64);
        return size_t'($urandom_range(65, 127));
    endfunction

    function automatic int area_of(size_t v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Offer one pixel word, hold it until taken, then maybe idle.
    task automatic send_pixel(pixel_word_t px);
        int gap;
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            input_stalls++;
            @(posedge aclk);
        end
        costs_model.note_pixel(px);
        words_sent++;
        gap = tx_idle ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering, let every predicted cost word arrive, then let the
    // pipeline empty before any register write.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (costs_model.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic write_size(cfg_reg_t idx, size_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        costs_model.set_size(idx, value);
        size_writes++;
        @(posedge aclk);
    endtask

    task automatic set_block(size_t w, size_t h);
        write_size(REG_BLOCK_WIDTH, w);
        write_size(REG_BLOCK_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure plus the one-off long hold-off
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    rx_stall = idle_gap();
            end
        end
    end

    // Cost word taken on this edge -> check against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            costs_model.check_costs(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    size_t w_pick, h_pick;
    int    area, count;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size 64 x 64: three rows with no register written, then the
        // height is cut to four so the next row closes the block
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        repeat (64 * 3) send_pixel(random_pixel());
        settle();
        write_size(REG_BLOCK_HEIGHT, size_t'(4));
        repeat (64) send_pixel(random_pixel());
        settle();

        // widest rows, every difference full scale
        set_block(size_t'(127), size_t'(4));
        rx_idle = 1'b0;
        repeat (127 * 4) begin
            if ($urandom_range(0, 1))
                send_pixel(make_px(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
            else
                send_pixel(make_px(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        end
        settle();

        // zero sizes act as one: every word closes a block
        set_block('0, '0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_pixel(make_px(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_px(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_px(8'h55, 8'hAA, 8'hAA, 8'h55, 8'h80));
        settle();

        // smallest intended block, then stop part-way into the next one
        set_block(size_t'(4), size_t'(4));
        repeat (22) send_pixel(random_pixel());
        settle();

        // shrink mid-block: counters already past the new limits
        set_block(size_t'(2), size_t'(1));
        repeat (3) send_pixel(random_pixel());
        settle();

        // a cost word per pixel while the output is held: input must stall
        set_block(size_t'(1), size_t'(1));
        tx_idle        = 1'b0;
        rx_hold_cycles = 300;
        repeat (40) send_pixel(random_pixel());
        settle();

        // random phases; partial blocks leave the counters mid-block so the
        // next size write lands in the middle of a block
        while (random_words < RANDOM_WORDS) begin
            w_pick = pick_size();
            h_pick = pick_size();
            if (area_of(w_pick) * area_of(h_pick) > 256)
                h_pick = size_t'($urandom_range(1, 2));
            set_block(w_pick, h_pick);
            area  = area_of(w_pick) * area_of(h_pick);
            count = area * $urandom_range(1, 4);
            if (area > 1 && $urandom_range(0, 2) == 0)
                count += $urandom_range(1, area - 1);
            if (count > RANDOM_WORDS - random_words)
                count = RANDOM_WORDS - random_words;
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (count) send_pixel(random_pixel());
            random_words += count;
            settle();
        end

        $display("Covered %0d pixel words (%0d random) and %0d cost words over %0d size writes,",
                 words_sent, random_words, costs_model.words_checked, size_writes);
        $display("including zero, oversize and full-scale blocks; input held for %0d cycles.",
                 input_stalls);
        if (costs_model.pending() != 0)
            $display("%0d cost words never arrived", costs_model.pending());
        if (costs_model.errors == 0 && costs_model.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
